// ===== hdl/deq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the double-ended queue unit: opcodes, status codes and the
// per-word control record passed from the pointer logic to the result stage.
// No dependencies.
package deq_pkg;

	// Default number of entries in the ring
	localparam int DEPTH_DEFAULT = 128;

	// Field widths fixed by the interface
	localparam int OPCODE_W = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 8;

	// Operation codes
	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_REAR  = 3'd5
	} op_t;

	// Status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What the result stage needs to know about one word
	typedef struct packed {
		logic    has_read;
		status_t status;
	} ctrl_info_t;

endpackage

// ===== hdl/deq_ram.sv =====
`timescale 1ns / 1ps
// Entry store of the deque: one write port, one read port, registered read.
// Uses deq_pkg for the value width.
module deq_ram #(
	parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [AW-1:0]                     wr_addr,
	input  logic [deq_pkg::VALUE_W-1:0]       wr_data,
	input  logic                              rd_en,
	input  logic [AW-1:0]                     rd_addr,
	output logic [deq_pkg::VALUE_W-1:0]       rd_data
);

	logic [deq_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [deq_pkg::VALUE_W-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/deq_ctrl.sv =====
`timescale 1ns / 1ps
// Head, tail and count registers of the deque; decodes each accepted word
// into a store access and the status it reports. Uses deq_pkg.
module deq_ctrl #(
	parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [deq_pkg::OPCODE_W-1:0]  opcode,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	output deq_pkg::ctrl_info_t           info,
	output logic [deq_pkg::OCC_W-1:0]     occ
);

	localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_d, tail_d;
	logic [CW-1:0] count_d;
	logic [AW-1:0] head_up, head_dn, tail_up, tail_dn;
	logic          is_empty, is_full;
	logic          do_wr, do_rd;
	logic [CW+deq_pkg::OCC_W-1:0] count_ext;

	// Wrapping neighbors of both pointers
	assign head_up = (head_q == IDX_LAST) ? '0 : head_q + AW'(1);
	assign head_dn = (head_q == '0) ? IDX_LAST : head_q - AW'(1);
	assign tail_up = (tail_q == IDX_LAST) ? '0 : tail_q + AW'(1);
	assign tail_dn = (tail_q == '0) ? IDX_LAST : tail_q - AW'(1);

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_FULL);

	// Decode one word
	always_comb begin
		head_d        = head_q;
		tail_d        = tail_q;
		count_d       = count_q;
		do_wr         = 1'b0;
		do_rd         = 1'b0;
		wr_addr       = tail_q;
		rd_addr       = head_q;
		info.has_read = 1'b0;
		info.status   = deq_pkg::ST_OK;
		unique case (deq_pkg::op_t'(opcode))
			deq_pkg::OP_PUSH_FRONT: begin
				wr_addr = head_dn;
				if (is_full) begin
					info.status = deq_pkg::ST_FULL;
				end else begin
					do_wr   = 1'b1;
					head_d  = head_dn;
					count_d = count_q + CW'(1);
				end
			end
			deq_pkg::OP_PUSH_REAR: begin
				wr_addr = tail_q;
				if (is_full) begin
					info.status = deq_pkg::ST_FULL;
				end else begin
					do_wr   = 1'b1;
					tail_d  = tail_up;
					count_d = count_q + CW'(1);
				end
			end
			deq_pkg::OP_POP_FRONT: begin
				rd_addr = head_q;
				if (is_empty) begin
					info.status = deq_pkg::ST_EMPTY;
				end else begin
					do_rd   = 1'b1;
					head_d  = head_up;
					count_d = count_q - CW'(1);
				end
			end
			deq_pkg::OP_POP_REAR: begin
				rd_addr = tail_dn;
				if (is_empty) begin
					info.status = deq_pkg::ST_EMPTY;
				end else begin
					do_rd   = 1'b1;
					tail_d  = tail_dn;
					count_d = count_q - CW'(1);
				end
			end
			deq_pkg::OP_PEEK_FRONT: begin
				rd_addr = head_q;
				if (is_empty) begin
					info.status = deq_pkg::ST_EMPTY;
				end else begin
					do_rd = 1'b1;
				end
			end
			deq_pkg::OP_PEEK_REAR: begin
				rd_addr = tail_dn;
				if (is_empty) begin
					info.status = deq_pkg::ST_EMPTY;
				end else begin
					do_rd = 1'b1;
				end
			end
			default: begin
				// unused codes: no operation
			end
		endcase
		info.has_read = do_rd;
	end

	assign wr_en = accept & do_wr;
	assign rd_en = accept & do_rd;

	// Occupancy carries the low bits of the count after the operation
	assign count_ext = {{deq_pkg::OCC_W{1'b0}}, count_d};
	assign occ       = count_ext[deq_pkg::OCC_W-1:0];

	// Pointer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== hdl/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// Double-ended queue unit: ring buffer in a synchronous RAM with head/tail/count.
// A result word is read from the RAM into stage 1 when its input word is accepted,
// then moves on to the output register when that register is free or not stalled.
// Throughput: one word per cycle while the result side is not stalled.
// Reset (arst_n, async, active low) empties the queue; the RAM is not cleared.
module double_ended_queue_unit #(
	parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [deq_pkg::OPCODE_W-1:0]        opcode,
	input  logic signed [deq_pkg::VALUE_W-1:0]  push_value,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [deq_pkg::VALUE_W-1:0]  result_value,
	output logic [deq_pkg::STATUS_W-1:0]        status,
	output logic [deq_pkg::OCC_W-1:0]           occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                          accept;
	logic                          wr_en, rd_en;
	logic [AW-1:0]                 wr_addr, rd_addr;
	logic [deq_pkg::VALUE_W-1:0]   rd_data;
	deq_pkg::ctrl_info_t           info;
	logic [deq_pkg::OCC_W-1:0]     occ;

	logic                          valid_s1;
	deq_pkg::ctrl_info_t           info_s1;
	logic [deq_pkg::OCC_W-1:0]     occ_s1;
	logic                          move_s1;

	logic                          out_valid_q;
	logic [deq_pkg::VALUE_W-1:0]   value_q;
	deq_pkg::status_t              status_q;
	logic [deq_pkg::OCC_W-1:0]     occ_q;

	// Handshake: stage 1 waits on RAM data and advances when the output frees
	assign move_s1    = valid_s1 & (~out_valid_q | ~result_stall);
	assign item_stall = valid_s1 & ~move_s1;
	assign accept     = item_valid & ~item_stall;

	deq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.opcode  (opcode),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.info    (info),
		.occ     (occ)
	);

	deq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (push_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
			occ_s1  <= occ;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (~result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (move_s1) begin
			value_q  <= info_s1.has_read ? rd_data : '0;
			status_q <= info_s1.status;
			occ_q    <= occ_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign result_value = value_q;
	assign status       = status_q;
	assign occupancy    = occ_q;

endmodule
